// ----- hw/rtl/ffdv_pkg.sv -----
package ffdv_pkg;

    localparam logic [5:0]  POS_PAYLOAD_START = 6'd20;
    localparam logic [5:0]  POS_CRC_START     = 6'd60;
    localparam logic [5:0]  POS_LAST          = 6'd63;
    localparam logic [13:0] PAYLOAD_BYTES     = 14'd40;
    localparam logic [31:0] CRC_POLY          = 32'hedb8_8320;
    localparam logic [31:0] CRC_INIT          = 32'hffff_ffff;
    localparam logic [7:0]  MAX_HOP           = 8'd8;
    localparam logic [7:0]  MAX_PRIORITY      = 8'd7;

    typedef enum logic [1:0] {
        ST_PAYLOAD = 2'd0,
        ST_VALID   = 2'd1,
        ST_INVALID = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        REG_VERSION    = 3'd0,
        REG_LOW_TYPE   = 3'd1,
        REG_HIGH_TYPE  = 3'd2,
        REG_PROBE_REQ  = 3'd3,
        REG_PROBE_RESP = 3'd4,
        REG_MAX_LEN    = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [7:0]  expected_version;
        logic [7:0]  lowest_type;
        logic [7:0]  highest_type;
        logic [7:0]  probe_request_type;
        logic [7:0]  probe_response_type;
        logic [13:0] max_total_length;
    } cfg_t;

    // packed with payload_byte in the lowest bits, as on the output bus
    typedef struct packed {
        logic [7:0]  priority_res;
        logic [7:0]  hop_budget;
        logic [15:0] total_length;
        logic [7:0]  fragment_count;
        logic [7:0]  fragment_index;
        logic [31:0] message_number;
        logic [31:0] session_number;
        logic [15:0] source;
        logic [15:0] destination;
        logic [7:0]  frame_type;
        logic [7:0]  payload_byte;
    } fields_t;

    typedef struct packed {
        logic    valid;
        status_t status;
        fields_t fields;
    } core_out_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

    // count * 40, fits 14 bits for any 8-bit count
    function automatic logic [13:0] times_payload(input logic [7:0] cnt);
        return 14'({cnt, 5'd0}) + 14'({cnt, 3'd0});
    endfunction

    // cnt == ceil(len / 40)
    function automatic logic count_matches(input logic [7:0] cnt, input logic [15:0] len);
        logic [13:0] upper;
        upper = times_payload(cnt);
        if (cnt == 8'd0) begin
            return len == 16'd0;
        end
        return (len <= {2'd0, upper}) && (len > {2'd0, upper - PAYLOAD_BYTES});
    endfunction

endpackage

// ----- hw/rtl/fixed_frame_decode_validate.sv -----
// a byte accepted into the input register moves on to the output register when
// that register is free or draining; its result beat is then held until taken
// throughput: one byte per cycle while results are taken; the crc byte update and
// the frame checks sit between the input register and the output register
// frame position, crc, padding state and config registers reset synchronously
// on aresetn low; the header store is not reset and is written before each use
module fixed_frame_decode_validate (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // data_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    // payload_byte, frame_type, destination, source, session_number,
    // message_number, fragment_index, fragment_count, total_length,
    // hop_budget, priority_res
    output logic [159:0] m_tdata,
    output logic [7:0]   m_tuser,   // status, zero fill
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [13:0]  cfg_data
);

    ffdv_pkg::cfg_t      cfg_reg;
    ffdv_pkg::core_out_t res;
    ffdv_pkg::fields_t   out_fields_reg;
    ffdv_pkg::status_t   out_status_reg;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg, out_valid_next;
    logic       advance;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.expected_version    <= 8'd1;
            cfg_reg.lowest_type         <= 8'd1;
            cfg_reg.highest_type        <= 8'd4;
            cfg_reg.probe_request_type  <= 8'd2;
            cfg_reg.probe_response_type <= 8'd3;
            cfg_reg.max_total_length    <= 14'd1024;
        end else if (cfg_valid) begin
            unique case (ffdv_pkg::cfg_index_t'(cfg_index))
                ffdv_pkg::REG_VERSION:    cfg_reg.expected_version    <= cfg_data[7:0];
                ffdv_pkg::REG_LOW_TYPE:   cfg_reg.lowest_type         <= cfg_data[7:0];
                ffdv_pkg::REG_HIGH_TYPE:  cfg_reg.highest_type        <= cfg_data[7:0];
                ffdv_pkg::REG_PROBE_REQ:  cfg_reg.probe_request_type  <= cfg_data[7:0];
                ffdv_pkg::REG_PROBE_RESP: cfg_reg.probe_response_type <= cfg_data[7:0];
                ffdv_pkg::REG_MAX_LEN:    cfg_reg.max_total_length    <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // the held byte moves on when the output register is free or draining
    assign advance       = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready      = !in_valid_reg || advance;
    assign in_valid_next = (s_tvalid && s_tready) || (in_valid_reg && !advance);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    ffdv_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .step    (advance),
        .byte_in (in_byte_reg),
        .res     (res)
    );

    assign out_valid_next = res.valid || (out_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res.valid) begin
            out_fields_reg <= res.fields;
            out_status_reg <= res.status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_fields_reg;
    assign m_tuser  = {6'd0, out_status_reg};

`ifndef SYNTH
    a_payload_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1:0] == ffdv_pkg::ST_PAYLOAD |-> m_tdata[159:8] == '0)
        else $error("payload beat carries header fields");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser[1:0] != 2'd3 && m_tuser[7:2] == 6'd0)
        else $error("undefined status on output beat");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("input stalled while pipeline can move");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_tready |-> !advance && !res.valid)
        else $error("result register overwritten while held");
`endif

endmodule

// ----- hw/rtl/ffdv_core.sv -----
module ffdv_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  ffdv_pkg::cfg_t      cfg,
    input  logic                step,
    input  logic [7:0]          byte_in,
    output ffdv_pkg::core_out_t res
);

    logic [5:0]  pos_reg;
    logic [31:0] crc_reg;
    logic [7:0]  rx_crc_reg [0:2];
    logic [7:0]  hdr_reg [0:19];
    logic [5:0]  pad_start_reg;
    logic        pad_err_reg;

    logic [7:0]  f_type, f_version, f_idx, f_cnt, f_hop, f_pri;
    logic [15:0] f_dst, f_src, f_len;
    logic [31:0] f_sess, f_msg;
    logic        is_probe, cnt_ok, in_payload, frame_ok, pad_err_next;
    logic [5:0]  pad_calc, pad_start_eff, offset;
    logic [15:0] pad_diff;
    logic [31:0] rx_crc_full;

    assign f_type    = hdr_reg[0];
    assign f_version = hdr_reg[1];
    assign f_dst     = {hdr_reg[3], hdr_reg[2]};
    assign f_src     = {hdr_reg[5], hdr_reg[4]};
    assign f_sess    = {hdr_reg[9], hdr_reg[8], hdr_reg[7], hdr_reg[6]};
    assign f_msg     = {hdr_reg[13], hdr_reg[12], hdr_reg[11], hdr_reg[10]};
    assign f_idx     = hdr_reg[14];
    assign f_cnt     = hdr_reg[15];
    assign f_len     = {hdr_reg[17], hdr_reg[16]};
    assign f_hop     = hdr_reg[18];
    assign f_pri     = hdr_reg[19];

    assign is_probe = (f_type == cfg.probe_request_type) || (f_type == cfg.probe_response_type);
    assign cnt_ok   = ffdv_pkg::count_matches(f_cnt, f_len);

    // bytes of the last fragment past the message end, and all probe payload bytes, must be zero
    assign pad_diff = f_len - {2'd0, ffdv_pkg::times_payload(f_cnt) - ffdv_pkg::PAYLOAD_BYTES};
    always_comb begin
        priority if (is_probe) begin
            pad_calc = 6'd0;
        end else if (f_idx == f_cnt && f_cnt != 8'd0 && cnt_ok) begin
            pad_calc = pad_diff[5:0];
        end else begin
            pad_calc = ffdv_pkg::PAYLOAD_BYTES[5:0];
        end
    end

    assign in_payload    = (pos_reg >= ffdv_pkg::POS_PAYLOAD_START)
                        && (pos_reg < ffdv_pkg::POS_CRC_START);
    assign offset        = pos_reg - ffdv_pkg::POS_PAYLOAD_START;
    assign pad_start_eff = (pos_reg == ffdv_pkg::POS_PAYLOAD_START) ? pad_calc : pad_start_reg;
    assign pad_err_next  = pad_err_reg
                        || (in_payload && offset >= pad_start_eff && byte_in != 8'd0);

    assign rx_crc_full = {byte_in, rx_crc_reg[2], rx_crc_reg[1], rx_crc_reg[0]};

    always_comb begin
        frame_ok = 1'b1;
        if (f_version != cfg.expected_version) frame_ok = 1'b0;
        if (~crc_reg != rx_crc_full) frame_ok = 1'b0;
        if (f_type < cfg.lowest_type || f_type > cfg.highest_type) frame_ok = 1'b0;
        if (f_msg == 32'd0 || f_hop == 8'd0 || f_hop > ffdv_pkg::MAX_HOP) frame_ok = 1'b0;
        if (f_pri > ffdv_pkg::MAX_PRIORITY) frame_ok = 1'b0;
        if (is_probe) begin
            if (f_sess != 32'd0 || f_len != 16'd0 || f_cnt != 8'd1 || f_idx != 8'd1
                || f_hop != 8'd1 || pad_err_reg) frame_ok = 1'b0;
        end else begin
            if (f_sess == 32'd0 || f_len == 16'd0
                || f_len > {2'd0, cfg.max_total_length}) frame_ok = 1'b0;
            if (!cnt_ok || f_idx == 8'd0 || f_idx > f_cnt) frame_ok = 1'b0;
            if (f_idx == f_cnt && pad_err_reg) frame_ok = 1'b0;
        end
    end

    always_comb begin
        res        = '0;
        res.status = ffdv_pkg::ST_PAYLOAD;
        if (pos_reg == ffdv_pkg::POS_LAST) begin
            res.valid                 = step;
            res.status                = frame_ok ? ffdv_pkg::ST_VALID : ffdv_pkg::ST_INVALID;
            res.fields.frame_type     = f_type;
            res.fields.destination    = f_dst;
            res.fields.source         = f_src;
            res.fields.session_number = f_sess;
            res.fields.message_number = f_msg;
            res.fields.fragment_index = f_idx;
            res.fields.fragment_count = f_cnt;
            res.fields.total_length   = f_len;
            res.fields.hop_budget     = f_hop;
            res.fields.priority_res   = f_pri;
        end else if (in_payload) begin
            res.valid               = step;
            res.fields.payload_byte = byte_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            crc_reg       <= ffdv_pkg::CRC_INIT;
            pad_start_reg <= '0;
            pad_err_reg   <= 1'b0;
        end else if (step) begin
            pos_reg <= pos_reg + 6'd1;
            if (pos_reg < ffdv_pkg::POS_CRC_START) begin
                crc_reg <= ffdv_pkg::crc_byte(crc_reg, byte_in);
            end else if (pos_reg == ffdv_pkg::POS_LAST) begin
                crc_reg <= ffdv_pkg::CRC_INIT;
            end
            if (pos_reg == ffdv_pkg::POS_PAYLOAD_START) begin
                pad_start_reg <= pad_calc;
            end
            pad_err_reg <= (pos_reg == ffdv_pkg::POS_LAST) ? 1'b0 : pad_err_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && pos_reg < ffdv_pkg::POS_PAYLOAD_START) begin
            hdr_reg[pos_reg[4:0]] <= byte_in;
        end
        if (step && pos_reg >= ffdv_pkg::POS_CRC_START && pos_reg != ffdv_pkg::POS_LAST) begin
            rx_crc_reg[pos_reg[1:0]] <= byte_in;
        end
    end

endmodule

// ----- test/fixed_frame_decode_validate_tb.sv -----
`timescale 1ns / 1ps

module fixed_frame_decode_validate_tb;

    localparam int N_DIRECTED = 12;
    localparam int N_PHASES = 4;
    localparam int FRAMES_PER_PHASE = 1;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 8;
    localparam ffdv_pkg::cfg_t RESET_RULES = '{8'd1, 8'd1, 8'd4, 8'd2, 8'd3, 14'd1024};

    typedef enum logic [1:0] {WANT_ANY, WANT_VALID, WANT_INVALID} want_t;
    typedef enum logic [1:0] {PL_ZERO, PL_PADDED, PL_RANDOM, PL_DIRTY} pl_mode_t;
    typedef enum logic [1:0] {RAW_NONE, RAW_FILL, RAW_NOISE} raw_t;

    typedef struct {
        logic [7:0]  ftype;
        logic [7:0]  ver;
        logic [15:0] dst;
        logic [15:0] src;
        logic [31:0] sess;
        logic [31:0] msg;
        logic [7:0]  idx;
        logic [7:0]  cnt;
        logic [15:0] len;
        logic [7:0]  hop;
        logic [7:0]  pri;
        pl_mode_t    pl;
        bit          crc_ok;
        raw_t        raw;
        logic [7:0]  fill;
        want_t       want;
    } frame_desc_t;

    typedef struct {
        ffdv_pkg::status_t status;
        ffdv_pkg::fields_t f;
        want_t             want;
    } beat_t;

    logic         aclk;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = 8'd0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [159:0] m_tdata;
    logic [7:0]   m_tuser;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = 3'd0;
    logic [13:0]  cfg_data = 14'd0;
    logic         long_hold = 1'b0;

    fixed_frame_decode_validate u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // frame decoder mirror
    ffdv_pkg::cfg_t rules = RESET_RULES;
    logic [5:0]     frame_pos = 6'd0;
    logic [31:0]    crc_acc = ffdv_pkg::CRC_INIT;
    logic [31:0]    crc_rx = 32'd0;
    logic [7:0]     hdr [20];
    int             zero_from = 0;
    bit             pad_dirty = 1'b0;
    want_t          frame_want = WANT_ANY;
    beat_t          beats_due [$];
    int             mismatches = 0;
    int             beats_seen = 0;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("[fixed_frame_decode_validate] ERROR");
        $finish;
    end

    function automatic logic [31:0] crc_update(input logic [31:0] acc, input logic [7:0] b);
        logic [31:0] c;
        c = acc ^ {24'd0, b};
        repeat (8) c = c[0] ? ((c >> 1) ^ ffdv_pkg::CRC_POLY) : (c >> 1);
        return c;
    endfunction

    function automatic bit is_probe(input logic [7:0] ftype);
        return ftype == rules.probe_request_type || ftype == rules.probe_response_type;
    endfunction

    // payload offset from which every byte must be zero
    function automatic int zero_offset(input logic [7:0] ftype, idx, cnt,
                                       input logic [15:0] len);
        int n;
        int c;
        n = len;
        c = cnt;
        if (is_probe(ftype)) return 0;
        if (idx == cnt && c >= 1 && c == (n + 39) / 40) return n - (c - 1) * 40;
        return 40;
    endfunction

    function automatic bit frame_passes();
        logic [7:0]  ftype;
        logic [7:0]  idx;
        logic [7:0]  cnt;
        logic [7:0]  hop;
        logic [7:0]  pri;
        logic [31:0] sess;
        logic [31:0] msg;
        int          len;
        int          need;
        ftype = hdr[0];
        idx = hdr[14];
        cnt = hdr[15];
        hop = hdr[18];
        pri = hdr[19];
        sess = {hdr[9], hdr[8], hdr[7], hdr[6]};
        msg = {hdr[13], hdr[12], hdr[11], hdr[10]};
        len = {hdr[17], hdr[16]};
        need = (len + 39) / 40;
        if (hdr[1] != rules.expected_version) return 1'b0;
        if ((crc_acc ^ 32'hffff_ffff) != crc_rx) return 1'b0;
        if (ftype < rules.lowest_type || ftype > rules.highest_type || msg == 0 ||
            hop == 0 || hop > ffdv_pkg::MAX_HOP || pri > ffdv_pkg::MAX_PRIORITY) return 1'b0;
        if (is_probe(ftype)) begin
            if (sess != 0 || len != 0 || cnt != 1 || idx != 1 || hop != 1) return 1'b0;
            return !pad_dirty;
        end
        if (sess == 0 || len == 0 || len > rules.max_total_length) return 1'b0;
        if (cnt != need || idx == 0 || idx > cnt) return 1'b0;
        if (idx == cnt && pad_dirty) return 1'b0;
        return 1'b1;
    endfunction

    function automatic void take_byte(input logic [7:0] b);
        logic [5:0] p;
        beat_t      nb;
        p = frame_pos;
        frame_pos = frame_pos + 6'd1;
        nb.f = '0;
        nb.want = WANT_ANY;
        if (p < ffdv_pkg::POS_CRC_START) crc_acc = crc_update(crc_acc, b);
        if (p < ffdv_pkg::POS_PAYLOAD_START) begin
            hdr[p] = b;
        end else if (p < ffdv_pkg::POS_CRC_START) begin
            if (p == ffdv_pkg::POS_PAYLOAD_START)
                zero_from = zero_offset(hdr[0], hdr[14], hdr[15], {hdr[17], hdr[16]}) & 63;
            if (int'(p) - 20 >= zero_from && b != 0) pad_dirty = 1'b1;
            nb.status = ffdv_pkg::ST_PAYLOAD;
            nb.f.payload_byte = b;
            beats_due.push_back(nb);
        end else begin
            crc_rx = crc_rx | ({24'd0, b} << (8 * (p - ffdv_pkg::POS_CRC_START)));
            if (p == ffdv_pkg::POS_LAST) begin
                nb.status = frame_passes() ? ffdv_pkg::ST_VALID : ffdv_pkg::ST_INVALID;
                nb.f.frame_type = hdr[0];
                nb.f.destination = {hdr[3], hdr[2]};
                nb.f.source = {hdr[5], hdr[4]};
                nb.f.session_number = {hdr[9], hdr[8], hdr[7], hdr[6]};
                nb.f.message_number = {hdr[13], hdr[12], hdr[11], hdr[10]};
                nb.f.fragment_index = hdr[14];
                nb.f.fragment_count = hdr[15];
                nb.f.total_length = {hdr[17], hdr[16]};
                nb.f.hop_budget = hdr[18];
                nb.f.priority_res = hdr[19];
                nb.want = frame_want;
                beats_due.push_back(nb);
                crc_acc = ffdv_pkg::CRC_INIT;
                crc_rx = 32'd0;
                pad_dirty = 1'b0;
            end
        end
    endfunction

    // mostly no wait, sometimes a short one, rarely a long one
    function automatic int pause_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic frame_desc_t base_frame();
        frame_desc_t d;
        d.ftype = 8'd1;
        d.ver = 8'd1;
        d.dst = 16'ha55a;
        d.src = 16'h0001;
        d.sess = 32'hffff_ffff;
        d.msg = 32'h0000_0001;
        d.idx = 8'd1;
        d.cnt = 8'd1;
        d.len = 16'd40;
        d.hop = 8'd1;
        d.pri = 8'd0;
        d.pl = PL_PADDED;
        d.crc_ok = 1'b1;
        d.raw = RAW_NONE;
        d.fill = 8'd0;
        d.want = WANT_ANY;
        return d;
    endfunction

    function automatic frame_desc_t as_probe(input frame_desc_t d, input logic [7:0] code);
        d.ftype = code;
        d.sess = 32'd0;
        d.len = 16'd0;
        d.cnt = 8'd1;
        d.idx = 8'd1;
        d.hop = 8'd1;
        d.pl = PL_ZERO;
        return d;
    endfunction

    // hand-written frames, run under the power-on register values
    function automatic frame_desc_t directed_row(input int i);
        frame_desc_t d;
        d = base_frame();
        d.want = WANT_INVALID;
        case (i)
            0:  d.want = WANT_VALID;
            1:  begin
                d.len = 16'd1; d.dst = 16'h0000; d.src = 16'hffff;
                d.msg = 32'hffff_ffff; d.hop = 8'd8; d.pri = 8'd7; d.want = WANT_VALID;
            end
            2:  begin d = as_probe(d, 8'd2); d.want = WANT_VALID; end
            3:  d.crc_ok = 1'b0;
            4:  d.ftype = 8'd5;
            5:  d.hop = 8'd9;
            6:  begin d = as_probe(d, 8'd3); d.pl = PL_DIRTY; d.want = WANT_INVALID; end
            7:  d.sess = 32'd0;
            8:  begin d.len = 16'd1025; d.cnt = 8'd26; d.idx = 8'd26; end
            9:  begin d.len = 16'd1024; d.cnt = 8'd26; d.idx = 8'd26; d.want = WANT_VALID; end
            10: begin d.len = 16'd1024; d.cnt = 8'd26; d.idx = 8'd26; d.pl = PL_DIRTY; end
            default: d.cnt = 8'd2;
        endcase
        return d;
    endfunction

    // well-formed frame for the current registers, sometimes with one or more defects
    function automatic frame_desc_t random_frame();
        frame_desc_t d;
        int          cap;
        d = base_frame();
        d.ver = rules.expected_version;
        if (rules.lowest_type <= rules.highest_type)
            d.ftype = $urandom_range(rules.lowest_type, rules.highest_type);
        else
            d.ftype = $urandom_range(0, 255);
        if ($urandom_range(0, 4) == 0)
            d.ftype = $urandom_range(0, 1) ? rules.probe_request_type : rules.probe_response_type;
        d.dst = $urandom;
        d.src = $urandom;
        d.msg = $urandom;
        if (d.msg == 0) d.msg = 32'd1;
        d.hop = $urandom_range(1, 8);
        d.pri = $urandom_range(0, 7);
        if (is_probe(d.ftype)) begin
            d = as_probe(d, d.ftype);
            if ($urandom_range(0, 4) == 0) d.pl = PL_RANDOM;
        end else begin
            d.sess = $urandom;
            if (d.sess == 0) d.sess = 32'd1;
            cap = rules.max_total_length;
            if (cap > 10200) cap = 10200;
            if (cap == 0) cap = 1;
            if ($urandom_range(0, 9) < 7)
                d.len = $urandom_range(1, (cap < 120) ? cap : 120);
            else
                d.len = $urandom_range(1, cap);
            d.cnt = (int'(d.len) + 39) / 40;
            d.idx = $urandom_range(0, 1) ? d.cnt : 8'($urandom_range(1, d.cnt));
            d.pl = ($urandom_range(0, 4) == 0) ? PL_RANDOM : PL_PADDED;
        end
        if ($urandom_range(0, 99) < 35) begin
            case ($urandom_range(0, 13))
                0:  d.ver = $urandom;
                1:  d.crc_ok = 1'b0;
                2:  d.ftype = $urandom;
                3:  d.msg = 32'd0;
                4:  d.hop = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(9, 255));
                5:  d.pri = $urandom_range(8, 255);
                6:  d.sess = (d.sess == 0) ? 32'($urandom) : 32'd0;
                7:  d.len = 16'd0;
                8:  d.len = $urandom;
                9:  d.cnt = $urandom;
                10: d.idx = $urandom_range(0, 1) ? 8'd0 : d.cnt + 8'd1;
                11: d.pl = PL_DIRTY;
                12: d.raw = RAW_NOISE;
                default: begin
                    d.idx = $urandom; d.cnt = $urandom; d.len = $urandom;
                    d.hop = $urandom; d.pri = $urandom; d.sess = $urandom;
                end
            endcase
        end
        return d;
    endfunction

    function automatic ffdv_pkg::cfg_t phase_settings(input int ph);
        ffdv_pkg::cfg_t c;
        case (ph)
            0: c = '{8'd0, 8'd0, 8'd255, 8'd255, 8'd0, 14'd10200};
            1: c = '{8'd255, 8'd200, 8'd255, 8'haa, 8'h55, 14'd1};
            2: begin
                c.expected_version = $urandom;
                c.lowest_type = $urandom_range(0, 120);
                c.highest_type = $urandom_range(c.lowest_type, 255);
                c.probe_request_type = $urandom_range(c.lowest_type, c.highest_type);
                c.probe_response_type = $urandom_range(0, 255);
                c.max_total_length = $urandom_range(1, 10200);
            end
            default: c = RESET_RULES;
        endcase
        return c;
    endfunction

    task automatic apply_settings(input ffdv_pkg::cfg_t c);
        ffdv_pkg::cfg_index_t regs [6];
        logic [13:0]          vals [6];
        regs[0] = ffdv_pkg::REG_VERSION;    vals[0] = {6'd0, c.expected_version};
        regs[1] = ffdv_pkg::REG_LOW_TYPE;   vals[1] = {6'd0, c.lowest_type};
        regs[2] = ffdv_pkg::REG_HIGH_TYPE;  vals[2] = {6'd0, c.highest_type};
        regs[3] = ffdv_pkg::REG_PROBE_REQ;  vals[3] = {6'd0, c.probe_request_type};
        regs[4] = ffdv_pkg::REG_PROBE_RESP; vals[4] = {6'd0, c.probe_response_type};
        regs[5] = ffdv_pkg::REG_MAX_LEN;    vals[5] = c.max_total_length;
        for (int i = 0; i < 6; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data <= vals[i];
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        rules = c;
    endtask

    task automatic send_frame(input frame_desc_t d);
        logic [7:0]  fb [64];
        logic [31:0] crc;
        int          zo;
        int          gap;
        bit          calm;
        fb[0] = d.ftype;       fb[1] = d.ver;
        fb[2] = d.dst[7:0];    fb[3] = d.dst[15:8];
        fb[4] = d.src[7:0];    fb[5] = d.src[15:8];
        for (int i = 0; i < 4; i++) begin
            fb[6 + i] = d.sess[8*i +: 8];
            fb[10 + i] = d.msg[8*i +: 8];
        end
        fb[14] = d.idx;        fb[15] = d.cnt;
        fb[16] = d.len[7:0];   fb[17] = d.len[15:8];
        fb[18] = d.hop;        fb[19] = d.pri;
        zo = zero_offset(d.ftype, d.idx, d.cnt, d.len);
        for (int i = 0; i < 40; i++) begin
            case (d.pl)
                PL_ZERO:   fb[20 + i] = 8'd0;
                PL_RANDOM: fb[20 + i] = $urandom;
                default:   fb[20 + i] = (i < zo) ? 8'($urandom) : 8'd0;
            endcase
        end
        if (d.pl == PL_DIRTY && zo < 40) fb[20 + $urandom_range(zo, 39)] = $urandom_range(1, 255);
        crc = ffdv_pkg::CRC_INIT;
        for (int i = 0; i < 60; i++) crc = crc_update(crc, fb[i]);
        crc = ~crc;
        if (!d.crc_ok) crc = crc ^ (32'd1 << $urandom_range(0, 31));
        for (int i = 0; i < 4; i++) fb[60 + i] = crc[8*i +: 8];
        if (d.raw != RAW_NONE)
            for (int i = 0; i < 64; i++) fb[i] = (d.raw == RAW_FILL) ? d.fill : 8'($urandom);
        calm = ($urandom_range(0, 3) == 0);
        frame_want = d.want;
        for (int i = 0; i < 64; i++) begin
            gap = calm ? 0 : pause_len();
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata <= fb[i];
            do @(posedge aclk); while (!s_tready);
            take_byte(fb[i]);
        end
    endtask

    // the decoder goes quiet once every beat is back and the pipe has drained
    task automatic settle();
        s_tvalid <= 1'b0;
        while (beats_due.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on beat %0d, %s: got 0x%0h, want 0x%0h",
                 beats_seen, what, got, want);
        mismatches++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    always @(posedge aclk) begin : result_check
        beat_t             want_beat;
        ffdv_pkg::fields_t got;
        if (aresetn && m_tvalid && m_tready) begin
            if (beats_due.size() == 0) begin
                report_mismatch("beat with nothing pending", {24'd0, m_tuser}, 32'd0);
            end else begin
                want_beat = beats_due.pop_front();
                got = m_tdata;
                check_field("status", {24'd0, m_tuser}, {30'd0, want_beat.status});
                if (want_beat.want != WANT_ANY)
                    check_field("verdict", {30'd0, m_tuser[1:0]},
                                {30'd0, (want_beat.want == WANT_VALID) ?
                                        ffdv_pkg::ST_VALID : ffdv_pkg::ST_INVALID});
                check_field("payload_byte", got.payload_byte, want_beat.f.payload_byte);
                check_field("frame_type", got.frame_type, want_beat.f.frame_type);
                check_field("destination", got.destination, want_beat.f.destination);
                check_field("source", got.source, want_beat.f.source);
                check_field("session_number", got.session_number,
                            want_beat.f.session_number);
                check_field("message_number", got.message_number,
                            want_beat.f.message_number);
                check_field("fragment_index", got.fragment_index, want_beat.f.fragment_index);
                check_field("fragment_count", got.fragment_count, want_beat.f.fragment_count);
                check_field("total_length", got.total_length, want_beat.f.total_length);
                check_field("hop_budget", got.hop_budget, want_beat.f.hop_budget);
                check_field("priority_res", got.priority_res, want_beat.f.priority_res);
            end
            beats_seen++;
        end
    end

    // result side back-pressure, with one long hold-off on request
    initial begin : result_sink
        int stall_left;
        int mode_left;
        int hold_left;
        bit calm;
        bit hold_done;
        stall_left = 0;
        mode_left = 0;
        hold_left = 0;
        calm = 1'b0;
        hold_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (long_hold && !hold_done) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                calm = ($urandom_range(0, 3) == 0);
                mode_left = $urandom_range(50, 200);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (!calm) stall_left = pause_len();
            end
        end
    end

    initial begin : stimulus
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (int i = 0; i < N_DIRECTED; i++) send_frame(directed_row(i));
        for (int ph = 0; ph < N_PHASES; ph++) begin
            settle();
            apply_settings(phase_settings(ph));
            for (int k = 0; k < FRAMES_PER_PHASE; k++) begin
                // stop the sink while bytes keep coming so the input backs up
                if (ph == 2 && k == 0) long_hold <= 1'b1;
                send_frame(random_frame());
            end
        end
        settle();
        if (mismatches == 0) begin
            $display("[fixed_frame_decode_validate] OK");
        end else begin
            $display("[fixed_frame_decode_validate] ERROR");
        end
        $finish;
    end

endmodule
